// ===== rtl/ccsa_pkg.sv =====
// Shared widths, defaults, command and state encodings for the circular slot allocator.
`default_nettype none
package ccsa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam int unsigned CNT_W         = 7;   // slot counts, run lengths, results
  localparam int unsigned START_W       = 6;
  localparam int unsigned OFS_W         = 8;   // scan offset, spans up to two laps
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 3;

  localparam logic [CNT_W-1:0] NUM_SLOTS_RST = CNT_W'(MAX_SLOTS_DEF);

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic REG_NUM_SLOTS = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

endpackage : ccsa_pkg
`default_nettype wire

// ===== rtl/ccsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ccsa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ccsa_ram
`default_nettype wire

// ===== rtl/circular_contiguous_slot_allocator.sv =====
// Circular first-fit contiguous slot allocator: top level.
// Per item: the start slot is first reduced modulo n by repeated subtraction,
//   then a store scans one slot a cycle around the ring and writes len
//   slots; a release writes min(len,n) slots. One item at a time (busy).
// The result strobes for one cycle once the decision is made; the ring marks
//   go through the one-bit map RAM one entry a cycle from the strobe's cycle on, unless a num_slots write intervenes.
// Reset and every num_slots write run a clearing pass over all MAX_SLOTS map entries.
`default_nettype none
module circular_contiguous_slot_allocator
  import ccsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic [START_W-1:0] in_start_slot,
  input  wire logic [CNT_W-1:0]   in_run_length,
  output logic                    out_valid,
  output logic                    out_failed,
  output logic [CNT_W-1:0]        out_value,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   num_slots_r, num_slots_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic               cmd_r, cmd_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   base_r, base_nxt;
  logic [OFS_W-1:0]   cand_r, cand_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]      cand_addr_r, cand_addr_nxt;
  logic [AW-1:0]      scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]      w_addr_r, w_addr_nxt;
  logic [CNT_W-1:0]   w_left_r, w_left_nxt;
  logic               w_bit_r, w_bit_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_failed_r, out_failed_nxt;
  logic [CNT_W-1:0]   out_value_r, out_value_nxt;

  logic [CNT_W-1:0]   n_eff;
  logic [AW-1:0]      last_addr;
  logic [CNT_W-1:0]   tgt;
  logic [OFS_W-1:0]   skip_ofs;
  logic [OFS_W-1:0]   run_cnt;
  logic [OFS_W-1:0]   rel_sum;
  logic               cfg_wr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic               ram_rdata;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a, input logic [AW-1:0] last);
    return (a == last) ? '0 : a + AW'(1);
  endfunction

  // Effective ring size: zero acts as one, clamp to the map depth.
  always_comb begin
    if (num_slots_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_slots_r) > int'(MAX_SLOTS)) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = num_slots_r;
    end
  end

  assign last_addr = AW'(n_eff - CNT_W'(1));
  assign tgt       = (len_r == '0) ? CNT_W'(1) : len_r;
  assign skip_ofs  = cand_r + OFS_W'(cnt_r) + OFS_W'(1);
  assign run_cnt   = OFS_W'(cnt_r) + OFS_W'(1);
  assign rel_sum   = OFS_W'(fc_r) + OFS_W'(len_r);
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_failed = out_failed_r;
  assign out_value = out_value_r;
  assign pready    = 1'b1;
  assign prdata    = DATA_W'(num_slots_r);

  always_comb begin
    state_nxt      = state_r;
    num_slots_nxt  = num_slots_r;
    fc_nxt         = fc_r;
    cmd_nxt        = cmd_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    base_nxt       = base_r;
    cand_nxt       = cand_r;
    cnt_nxt        = cnt_r;
    cand_addr_nxt  = cand_addr_r;
    scan_addr_nxt  = scan_addr_r;
    rd_addr_nxt    = rd_addr_r;
    rd_vld_nxt     = 1'b0;
    w_addr_nxt     = w_addr_r;
    w_left_nxt     = w_left_r;
    w_bit_nxt      = w_bit_r;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = 1'b0;
    out_failed_nxt = out_failed_r;
    out_value_nxt  = out_value_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          start_nxt = in_start_slot;
          len_nxt   = in_run_length;
          base_nxt  = CNT_W'(in_start_slot);
          state_nxt = ST_MOD;
        end
      end

      ST_MOD: begin
        if (base_r >= n_eff) begin
          base_nxt = base_r - n_eff;
        end else if (cmd_r == CMD_RELEASE) begin
          out_valid_nxt  = 1'b1;
          out_failed_nxt = 1'b0;
          out_value_nxt  = len_r;
          fc_nxt         = (rel_sum > OFS_W'(n_eff)) ? n_eff : CNT_W'(rel_sum);
          w_left_nxt     = (len_r < n_eff) ? len_r : n_eff;
          w_addr_nxt     = AW'(base_r);
          w_bit_nxt      = 1'b0;
          state_nxt      = (len_r != '0) ? ST_WRITE : ST_IDLE;
        end else if (len_r > fc_r) begin
          out_valid_nxt  = 1'b1;
          out_failed_nxt = 1'b1;
          out_value_nxt  = '0;
          state_nxt      = ST_IDLE;
        end else begin
          scan_addr_nxt = AW'(base_r);
          cand_addr_nxt = AW'(base_r);
          cand_nxt      = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end

      // Issue one read a cycle; judge the slot whose read was issued in the previous cycle.
      // Reads run strictly in ring order, so a restart of the run never
      // needs to reissue the read already in flight.
      ST_SCAN: begin
        rd_vld_nxt    = 1'b1;
        rd_addr_nxt   = scan_addr_r;
        scan_addr_nxt = ring_inc(scan_addr_r, last_addr);
        if (rd_vld_r) begin
          if (ram_rdata) begin
            if (skip_ofs >= OFS_W'(n_eff)) begin
              out_valid_nxt  = 1'b1;
              out_failed_nxt = 1'b1;
              out_value_nxt  = '0;
              rd_vld_nxt     = 1'b0;
              state_nxt      = ST_IDLE;
            end else begin
              cand_nxt      = skip_ofs;
              cnt_nxt       = '0;
              cand_addr_nxt = ring_inc(rd_addr_r, last_addr);
            end
          end else if (run_cnt >= OFS_W'(tgt)) begin
            out_valid_nxt  = 1'b1;
            out_failed_nxt = 1'b0;
            out_value_nxt  = CNT_W'(OFS_W'(start_r) + cand_r);
            fc_nxt         = fc_r - len_r;
            w_addr_nxt     = cand_addr_r;
            w_left_nxt     = len_r;
            w_bit_nxt      = 1'b1;
            rd_vld_nxt     = 1'b0;
            state_nxt      = (len_r != '0) ? ST_WRITE : ST_IDLE;
          end else begin
            cnt_nxt = CNT_W'(run_cnt);
          end
        end
      end

      // Writes finish before the next item can read, so no forwarding needed.
      ST_WRITE: begin
        w_addr_nxt = ring_inc(w_addr_r, last_addr);
        w_left_nxt = w_left_r - CNT_W'(1);
        if (w_left_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        fc_nxt       = n_eff;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // Register write: reload the ring size and restart the clearing pass.
    if (cfg_wr && (paddr[2] == REG_NUM_SLOTS)) begin
      num_slots_nxt = pwdata[CNT_W-1:0];
      clr_addr_nxt  = '0;
      rd_vld_nxt    = 1'b0;
      state_nxt     = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      num_slots_r <= NUM_SLOTS_RST;
      fc_r        <= '0;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_slots_r <= num_slots_nxt;
      fc_r        <= fc_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    start_r      <= start_nxt;
    len_r        <= len_nxt;
    base_r       <= base_nxt;
    cand_r       <= cand_nxt;
    cnt_r        <= cnt_nxt;
    cand_addr_r  <= cand_addr_nxt;
    scan_addr_r  <= scan_addr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    w_addr_r     <= w_addr_nxt;
    w_left_r     <= w_left_nxt;
    w_bit_r      <= w_bit_nxt;
    out_failed_r <= out_failed_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_addr_r;
    ram_wdata = w_bit_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 1'b0;
    end else if (state_r == ST_WRITE) begin
      ram_we = 1'b1;
    end
  end

  ccsa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

endmodule : circular_contiguous_slot_allocator
`default_nettype wire

// ===== rtl/ccsa_chk.sv =====
// Port-level checker for the slot allocator, bound to the top level.
`default_nettype none
module ccsa_chk
  import ccsa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic               out_failed,
  input wire logic [CNT_W-1:0]   out_value,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [ADDR_W-1:0]  paddr
);

  // Reset always leaves the block sweeping the map.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("no clearing pass after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_failed) |-> (out_value == '0))
    else $error("failed store carries a nonzero value");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[2] == REG_NUM_SLOTS)) |=> busy)
    else $error("register write did not start a clearing pass");

endmodule : ccsa_chk

bind circular_contiguous_slot_allocator ccsa_chk u_ccsa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_failed (out_failed),
  .out_value  (out_value),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr)
);
`default_nettype wire
